// File: sv/rgbhsv_pkg.sv
`default_nettype none
package rgbhsv_pkg;

	// pixel and result channel width
	localparam int PIX_W = 8;
	// hue numerator in sixtieths: hue_deg * c / 60, at most 6 * 255
	localparam int M_W = 11;
	// divider dividend and divisor widths (85 * m and 2 * c)
	localparam int NUM_W = 17;
	localparam int DEN_W = 9;
	// quotient bit index width
	localparam int SH_W = $clog2(PIX_W);

	// hue = 85 * m / (2 * c), which is 17 * (60 * m) / (24 * c)
	localparam logic [PIX_W-1:0] HUE_SCALE = 8'd85;

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_RED_HUE_ABOVE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RED_HUE_BELOW = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RED_SAT_MIN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RED_VAL_MIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BLACK_HUE_MAX = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BLACK_SAT_MAX = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BLACK_VAL_MAX = 3'd6;

	// configuration reset values
	localparam logic [PIX_W-1:0] RST_RED_HUE_ABOVE = 8'd235;
	localparam logic [PIX_W-1:0] RST_RED_HUE_BELOW = 8'd10;
	localparam logic [PIX_W-1:0] RST_RED_SAT_MIN   = 8'd40;
	localparam logic [PIX_W-1:0] RST_RED_VAL_MIN   = 8'd30;
	localparam logic [PIX_W-1:0] RST_BLACK_HUE_MAX = 8'd240;
	localparam logic [PIX_W-1:0] RST_BLACK_SAT_MAX = 8'd155;
	localparam logic [PIX_W-1:0] RST_BLACK_VAL_MAX = 8'd70;

	// one division lane: partial remainder, divisor, quotient so far
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [PIX_W-1:0] quo;
	} div_lane_t;

	// payload between front end, divider and classifier
	typedef struct packed {
		div_lane_t        hue;
		div_lane_t        sat;
		logic [PIX_W-1:0] val;
	} div_bus_t;

	// class thresholds
	typedef struct packed {
		logic [PIX_W-1:0] red_hue_above;
		logic [PIX_W-1:0] red_hue_below;
		logic [PIX_W-1:0] red_sat_min;
		logic [PIX_W-1:0] red_val_min;
		logic [PIX_W-1:0] black_hue_max;
		logic [PIX_W-1:0] black_sat_max;
		logic [PIX_W-1:0] black_val_max;
	} cfg_t;

endpackage
`default_nettype wire

// File: sv/rgbhsv_front.sv
`default_nettype none
module rgbhsv_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0] red_in,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0] green_in,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0] blue_in,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output rgbhsv_pkg::div_bus_t           out_bus
);
	import rgbhsv_pkg::*;

	// which hue formula applies
	localparam logic [1:0] SEL_BLUE    = 2'd0;
	localparam logic [1:0] SEL_GREEN   = 2'd1;
	localparam logic [1:0] SEL_RED_POS = 2'd2;
	localparam logic [1:0] SEL_RED_NEG = 2'd3;

	logic             v_s1, v_s2, v_s3;
	logic             en_s1, en_s2, en_s3;

	logic [PIX_W-1:0] r_s1, g_s1, b_s1, mx_s1, c_s1;
	logic [1:0]       sel_s1;
	logic [M_W-1:0]   m_s2;
	logic [PIX_W-1:0] mx_s2, c_s2;
	logic [DEN_W-1:0] hden_s2, sden_s2;
	div_bus_t         bus_s3;

	logic [PIX_W-1:0] mx, mn;
	logic [1:0]       sel;
	logic [M_W-1:0]   m;
	logic [M_W-1:0]   c_w, r_w, g_w, b_w;

	// a stage loads when empty or when its successor moves
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: max, min and formula select (blue beats green beats red)
	always_comb begin
		mx = (red_in > green_in) ? red_in : green_in;
		if (blue_in > mx) mx = blue_in;
		mn = (red_in < green_in) ? red_in : green_in;
		if (blue_in < mn) mn = blue_in;
		if (mx == blue_in)        sel = SEL_BLUE;
		else if (mx == green_in)  sel = SEL_GREEN;
		else if (green_in >= blue_in) sel = SEL_RED_POS;
		else                      sel = SEL_RED_NEG;
	end

	// stage 2: hue numerator in sixtieths; wraps are harmless, result is in range
	assign c_w = M_W'(c_s1);
	assign r_w = M_W'(r_s1);
	assign g_w = M_W'(g_s1);
	assign b_w = M_W'(b_s1);

	always_comb begin
		case (sel_s1)
			SEL_BLUE:    m = (c_w << 2) + r_w - g_w;
			SEL_GREEN:   m = (c_w << 1) + b_w - r_w;
			SEL_RED_POS: m = g_w - b_w;
			SEL_RED_NEG: m = (c_w << 2) + (c_w << 1) + g_w - b_w;
			default:     m = '0;
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			r_s1   <= red_in;
			g_s1   <= green_in;
			b_s1   <= blue_in;
			mx_s1  <= mx;
			c_s1   <= mx - mn;
			sel_s1 <= sel;
		end
		if (en_s2 && v_s1) begin
			m_s2    <= m;
			mx_s2   <= mx_s1;
			c_s2    <= c_s1;
			// zero divisors only meet zero dividends; use one so quotient is zero
			hden_s2 <= (c_s1 == '0) ? DEN_W'(1) : {c_s1, 1'b0};
			sden_s2 <= (mx_s1 == '0) ? DEN_W'(1) : DEN_W'(mx_s1);
		end
		// stage 3: dividends
		if (en_s3 && v_s2) begin
			bus_s3.hue.rem <= NUM_W'(m_s2) * NUM_W'(HUE_SCALE);
			bus_s3.hue.den <= hden_s2;
			bus_s3.hue.quo <= '0;
			bus_s3.sat.rem <= (NUM_W'(c_s2) << PIX_W) - NUM_W'(c_s2);
			bus_s3.sat.den <= sden_s2;
			bus_s3.sat.quo <= '0;
			bus_s3.val     <= mx_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_bus   = bus_s3;

endmodule
`default_nettype wire

// File: sv/rgbhsv_div.sv
`default_nettype none
module rgbhsv_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire rgbhsv_pkg::div_bus_t  in_bus,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output rgbhsv_pkg::div_bus_t       out_bus
);
	import rgbhsv_pkg::*;

	// quotient bits resolved per stage, high pair first
	localparam logic [SH_W-1:0] TOP_S1 = SH_W'(PIX_W - 1);
	localparam logic [SH_W-1:0] TOP_S2 = SH_W'(PIX_W - 3);
	localparam logic [SH_W-1:0] TOP_S3 = SH_W'(PIX_W - 5);
	localparam logic [SH_W-1:0] TOP_S4 = SH_W'(PIX_W - 7);

	// two restoring steps on one lane
	function automatic div_lane_t div_pair(div_lane_t x, logic [SH_W-1:0] top);
		div_lane_t       y;
		logic [NUM_W:0]  trial;
		logic [SH_W-1:0] sh;
		y = x;
		for (int j = 0; j < 2; j++) begin
			sh    = top - SH_W'(j);
			trial = {1'b0, y.rem} - ({{(NUM_W + 1 - DEN_W){1'b0}}, y.den} << sh);
			if (!trial[NUM_W]) begin
				y.rem     = trial[NUM_W-1:0];
				y.quo[sh] = 1'b1;
			end
		end
		return y;
	endfunction

	function automatic div_bus_t bus_pair(div_bus_t b, logic [SH_W-1:0] top);
		div_bus_t o;
		o     = b;
		o.hue = div_pair(b.hue, top);
		o.sat = div_pair(b.sat, top);
		return o;
	endfunction

	logic     v_s1, v_s2, v_s3, v_s4;
	logic     en_s1, en_s2, en_s3, en_s4;
	div_bus_t d_s1, d_s2, d_s3, d_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// two quotient bits per stage
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) d_s1 <= bus_pair(in_bus, TOP_S1);
		if (en_s2 && v_s1)     d_s2 <= bus_pair(d_s1, TOP_S2);
		if (en_s3 && v_s2)     d_s3 <= bus_pair(d_s2, TOP_S3);
		if (en_s4 && v_s3)     d_s4 <= bus_pair(d_s3, TOP_S4);
	end

	assign out_valid = v_s4;
	assign out_bus   = d_s4;

endmodule
`default_nettype wire

// File: sv/rgbhsv_classify.sv
`default_nettype none
module rgbhsv_classify (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rgbhsv_pkg::cfg_t            cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire rgbhsv_pkg::div_bus_t        in_bus,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [rgbhsv_pkg::PIX_W-1:0]     hue_out,
	output logic [rgbhsv_pkg::PIX_W-1:0]     sat_out,
	output logic [rgbhsv_pkg::PIX_W-1:0]     val_out,
	output logic                             is_red,
	output logic                             is_black
);
	import rgbhsv_pkg::*;

	// round to nearest, ties to even; remainder is below the divisor
	function automatic logic [PIX_W-1:0] round_even(div_lane_t x);
		logic [DEN_W:0] twice;
		logic           up;
		twice = {x.rem[DEN_W-1:0], 1'b0};
		up    = (twice > {1'b0, x.den}) || ((twice == {1'b0, x.den}) && x.quo[0]);
		return x.quo + PIX_W'(up);
	endfunction

	logic             v_s1, v_s2;
	logic             en_s1, en_s2;
	logic [PIX_W-1:0] hue_s1, sat_s1, val_s1;
	logic [PIX_W-1:0] hue_s2, sat_s2, val_s2;
	logic             red_s2, black_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// stage 1 rounds, stage 2 compares against thresholds
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			hue_s1 <= round_even(in_bus.hue);
			sat_s1 <= round_even(in_bus.sat);
			val_s1 <= in_bus.val;
		end
		if (en_s2 && v_s1) begin
			hue_s2   <= hue_s1;
			sat_s2   <= sat_s1;
			val_s2   <= val_s1;
			red_s2   <= ((hue_s1 > cfg.red_hue_above) || (hue_s1 < cfg.red_hue_below))
				&& (sat_s1 > cfg.red_sat_min) && (val_s1 > cfg.red_val_min);
			black_s2 <= (hue_s1 <= cfg.black_hue_max) && (sat_s1 <= cfg.black_sat_max)
				&& (val_s1 <= cfg.black_val_max);
		end
	end

	assign out_valid = v_s2;
	assign hue_out   = hue_s2;
	assign sat_out   = sat_s2;
	assign val_out   = val_s2;
	assign is_red    = red_s2;
	assign is_black  = black_s2;

endmodule
`default_nettype wire

// File: sv/rgb_to_hsv_color_classifier_core.sv
// RGB to HSV converter with red and black class flags.
//
// Input channel: in_valid/in_ready carry one 8-bit R,G,B pixel per transaction.
// Output channel: out_valid/out_ready carry hue, saturation, value and the
// two class flags, one result transaction per pixel, in input order.
// Configuration: cfg_wr_en writes cfg_data into the threshold register
// selected by cfg_index (0..6); index 7 is ignored. Write only while idle.
//
// Nine register stages: 3 front-end stages (max/min, hue numerator,
// dividends), 4 divider stages resolving two quotient bits each for hue and
// saturation side by side, 1 rounding stage and 1 compare stage that is also
// the output register. Throughput is one pixel per cycle while the receiver
// keeps out_ready high.
//
// Reset clears every valid bit and loads the default thresholds.
// When the receiver stalls, each stage holds its transaction; empty stages
// keep filling, so in_ready drops only once the whole pipeline is full.
`default_nettype none
module rgb_to_hsv_color_classifier_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [rgbhsv_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0]      cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0]      red_in,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0]      green_in,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0]      blue_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [rgbhsv_pkg::PIX_W-1:0]           hue_out,
	output logic [rgbhsv_pkg::PIX_W-1:0]           sat_out,
	output logic [rgbhsv_pkg::PIX_W-1:0]           val_out,
	output logic                                   is_red,
	output logic                                   is_black
);
	import rgbhsv_pkg::*;

	cfg_t     cfg_q;
	logic     fr_valid, fr_ready;
	div_bus_t fr_bus;
	logic     dv_valid, dv_ready;
	div_bus_t dv_bus;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_hue_above <= RST_RED_HUE_ABOVE;
			cfg_q.red_hue_below <= RST_RED_HUE_BELOW;
			cfg_q.red_sat_min   <= RST_RED_SAT_MIN;
			cfg_q.red_val_min   <= RST_RED_VAL_MIN;
			cfg_q.black_hue_max <= RST_BLACK_HUE_MAX;
			cfg_q.black_sat_max <= RST_BLACK_SAT_MAX;
			cfg_q.black_val_max <= RST_BLACK_VAL_MAX;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RED_HUE_ABOVE: cfg_q.red_hue_above <= cfg_data;
				REG_RED_HUE_BELOW: cfg_q.red_hue_below <= cfg_data;
				REG_RED_SAT_MIN:   cfg_q.red_sat_min   <= cfg_data;
				REG_RED_VAL_MIN:   cfg_q.red_val_min   <= cfg_data;
				REG_BLACK_HUE_MAX: cfg_q.black_hue_max <= cfg_data;
				REG_BLACK_SAT_MAX: cfg_q.black_sat_max <= cfg_data;
				REG_BLACK_VAL_MAX: cfg_q.black_val_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// max/min, hue numerator and dividends
	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_bus   (fr_bus)
	);

	// hue and saturation division
	rgbhsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_bus    (fr_bus),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_bus   (dv_bus)
	);

	// rounding and class flags
	rgbhsv_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.in_bus    (dv_bus),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.val_out   (val_out),
		.is_red    (is_red),
		.is_black  (is_black)
	);

endmodule
`default_nettype wire

// File: sim/rgb_to_hsv_color_classifier_core_tb.sv
`default_nettype none
module rgb_to_hsv_color_classifier_core_tb;
	import rgbhsv_pkg::*;

	// index past the last threshold register; writes to it must be dropped
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [PIX_W-1:0] hue;
		logic [PIX_W-1:0] sat;
		logic [PIX_W-1:0] val;
		logic             red;
		logic             black;
	} hsv_result_t;

	// Tracks the thresholds, converts each accepted pixel and checks results in order
	class hsv_tracker;
		cfg_t        th;
		hsv_result_t pending_hsv[$];
		int unsigned errors;

		function new();
			th = '{RST_RED_HUE_ABOVE, RST_RED_HUE_BELOW, RST_RED_SAT_MIN, RST_RED_VAL_MIN,
				RST_BLACK_HUE_MAX, RST_BLACK_SAT_MAX, RST_BLACK_VAL_MAX};
			errors = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
			case (idx)
			REG_RED_HUE_ABOVE: th.red_hue_above = data;
			REG_RED_HUE_BELOW: th.red_hue_below = data;
			REG_RED_SAT_MIN:   th.red_sat_min   = data;
			REG_RED_VAL_MIN:   th.red_val_min   = data;
			REG_BLACK_HUE_MAX: th.black_hue_max = data;
			REG_BLACK_SAT_MAX: th.black_sat_max = data;
			REG_BLACK_VAL_MAX: th.black_val_max = data;
			default: ;
			endcase
		endfunction

		// exact ratio, round half to even, clamp to 8 bits
		function int unsigned ratio8(int unsigned num, int unsigned den);
			int unsigned q, rem;
			q = num / den;
			rem = num % den;
			if (2 * rem > den || (2 * rem == den && q[0]))
				q++;
			return (q > 255) ? 255 : q;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] r8, logic [PIX_W-1:0] g8, logic [PIX_W-1:0] b8);
			int unsigned r, g, b, mx, mn, c, hnum, hue, sat;
			hsv_result_t want;
			r = r8;
			g = g8;
			b = b8;
			mx = (r > g) ? r : g;
			if (b > mx) mx = b;
			mn = (r < g) ? r : g;
			if (b < mn) mn = b;
			c = mx - mn;
			sat = (mx != 0) ? ratio8(255 * c, mx) : 0;
			if (c == 0) begin
				hue = 0;
			end else begin
				// numerator of hue in degrees over c; blue wins ties, then green
				if (mx == b)
					hnum = 240 * c + 60 * r - 60 * g;
				else if (mx == g)
					hnum = 120 * c + 60 * b - 60 * r;
				else if (g >= b)
					hnum = 60 * (g - b);
				else
					hnum = 360 * c - 60 * (b - g);
				hue = ratio8(17 * hnum, 24 * c);
			end
			want.hue = hue[7:0];
			want.sat = sat[7:0];
			want.val = mx[7:0];
			want.red = (want.hue > th.red_hue_above || want.hue < th.red_hue_below)
				&& want.sat > th.red_sat_min && want.val > th.red_val_min;
			want.black = want.hue <= th.black_hue_max && want.sat <= th.black_sat_max
				&& want.val <= th.black_val_max;
			pending_hsv.push_back(want);
		endfunction

		function int unsigned pending_count();
			return pending_hsv.size();
		endfunction

		function void mismatch(string what, int want, int got);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		endfunction

		function void check_hsv(hsv_result_t got);
			hsv_result_t want;
			if (pending_hsv.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual h=%0d s=%0d v=%0d",
					$time, got.hue, got.sat, got.val);
				errors++;
				return;
			end
			want = pending_hsv.pop_front();
			if (got.hue !== want.hue) mismatch("hue_out", want.hue, got.hue);
			if (got.sat !== want.sat) mismatch("sat_out", want.sat, got.sat);
			if (got.val !== want.val) mismatch("val_out", want.val, got.val);
			if (got.red !== want.red) mismatch("is_red", want.red, got.red);
			if (got.black !== want.black) mismatch("is_black", want.black, got.black);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [PIX_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     red_in = '0;
	logic [PIX_W-1:0]     green_in = '0;
	logic [PIX_W-1:0]     blue_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIX_W-1:0]     hue_out;
	logic [PIX_W-1:0]     sat_out;
	logic [PIX_W-1:0]     val_out;
	logic                 is_red;
	logic                 is_black;

	hsv_tracker tracker = new();
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_stall_left = 0;

	// corner pixels: black, white, primaries, tied maxima, hue near the top,
	// exact halves in saturation and hue, grey and near-black
	logic [23:0] directed_px [20] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
		24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010000, 24'hFFFE00,
		24'hFF0001, 24'h020101, 24'h060505, 24'h060605, 24'h804000,
		24'h0A141E, 24'hC86496, 24'h7F7F7F, 24'h000001, 24'hFF8080
	};

	rgb_to_hsv_color_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.val_out   (val_out),
		.is_red    (is_red),
		.is_black  (is_black)
	);

	always #5 clk = ~clk;

	// a gap with idle_pct percent chance: mostly a short one, now and then a long one
	function automatic int unsigned pick_gap(int unsigned idle_pct);
		if ($urandom_range(99, 0) >= idle_pct) return 0;
		if ($urandom_range(9, 0) == 0) return $urandom_range(30, 6);
		return $urandom_range(3, 1);
	endfunction

	// result side: check each transaction, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_hsv('{hue_out, sat_out, val_out, is_red, is_black});
		if (rx_stall_left > 0) begin
			out_ready <= 1'b0;
			rx_stall_left--;
		end else begin
			rx_stall_left = pick_gap(rx_idle_pct);
			out_ready <= (rx_stall_left == 0);
			if (rx_stall_left > 0) rx_stall_left--;
		end
	end

	// valid stays high across back-to-back transactions; this task lowers it only for a gap
	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b, input int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_pixel(r, g, b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending_count() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	// every register plus the unused index; only called with the pipeline empty
	task automatic load_thresholds(input cfg_t t);
		put_reg(REG_UNUSED, 8'($urandom));
		put_reg(REG_RED_HUE_ABOVE, t.red_hue_above);
		put_reg(REG_RED_HUE_BELOW, t.red_hue_below);
		put_reg(REG_RED_SAT_MIN, t.red_sat_min);
		put_reg(REG_RED_VAL_MIN, t.red_val_min);
		put_reg(REG_BLACK_HUE_MAX, t.black_hue_max);
		put_reg(REG_BLACK_SAT_MAX, t.black_sat_max);
		put_reg(REG_BLACK_VAL_MAX, t.black_val_max);
		cfg_wr_en <= 1'b0;
	endtask

	// pixel mix: plain random, tied maxima, grey, tiny, extremes, close channels
	task automatic make_pixel(output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
		output logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] v;
		logic [PIX_W-1:0] ch [3];
		int unsigned kind, rot, pick;
		kind = $urandom_range(9, 0);
		v = 8'($urandom);
		for (int i = 0; i < 3; i++) begin
			case (kind)
			4, 5: ch[i] = (i == 0 || $urandom_range(1, 0)) ? v : 8'($urandom_range(v, 0));
			6: ch[i] = v;
			7: ch[i] = 8'($urandom_range(3, 0));
			8: begin
				pick = $urandom_range(3, 0);
				ch[i] = (pick < 2) ? 8'(pick) : 8'(252 + pick);
			end
			9: ch[i] = (v > 2) ? v - 8'($urandom_range(2, 0)) : 8'($urandom_range(2, 0));
			default: ch[i] = 8'($urandom);
			endcase
		end
		rot = $urandom_range(2, 0);
		r = ch[rot];
		g = ch[(rot + 1) % 3];
		b = ch[(rot + 2) % 3];
	endtask

	task automatic run_random(input int unsigned count);
		logic [PIX_W-1:0] r, g, b;
		for (int unsigned k = 0; k < count; k++) begin
			if (k % 64 == 0) begin
				tx_idle_pct = 20 * $urandom_range(4, 0);
				rx_idle_pct = 20 * $urandom_range(4, 0);
			end
			// hold off the sender until the pipeline is empty once per phase
			if (k == count / 2) wait_drained();
			make_pixel(r, g, b);
			send_pixel(r, g, b, pick_gap(tx_idle_pct));
		end
	endtask

	// stimulus: directed corners at reset thresholds, then random phases
	initial begin
		cfg_t setting;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 20; i++)
			send_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0],
				(i < 10) ? 0 : pick_gap(50));
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				wait_drained();
				case (ph)
				1: setting = '0;
				2: setting = '1;
				6: setting = '{RST_RED_HUE_ABOVE, RST_RED_HUE_BELOW, RST_RED_SAT_MIN,
					RST_RED_VAL_MIN, RST_BLACK_HUE_MAX, RST_BLACK_SAT_MAX, RST_BLACK_VAL_MAX};
				default: begin
					setting.red_hue_above = 8'($urandom);
					setting.red_hue_below = 8'($urandom);
					setting.red_sat_min   = 8'($urandom);
					setting.red_val_min   = 8'($urandom);
					setting.black_hue_max = 8'($urandom);
					setting.black_sat_max = 8'($urandom);
					setting.black_val_max = 8'($urandom);
				end
				endcase
				load_thresholds(setting);
			end
			run_random(215);
		end
		wait_drained();
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run limit
	initial begin
		#10000000;
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
